/* hw/rtl/f64rhu_pkg.sv */
// Package: constants and types for the float64 round-half-up core.
package f64rhu_pkg;

    localparam int unsigned DataW   = 64;
    localparam int unsigned FracW   = 52;
    localparam int unsigned ExpW    = 11;

    localparam logic [ExpW-1:0] ExpMax  = 11'h7FF;
    localparam logic [ExpW-1:0] ExpBias = 11'd1023;
    localparam logic [ExpW-1:0] ExpHalf = 11'd1022;
    localparam logic [ExpW-1:0] ExpInt  = 11'd1075;

    typedef logic [DataW-1:0] t_word;

    typedef struct packed {
        logic        pass;
        logic        sign;
        logic [FracW:0] n;
        t_word       word;
    } t_mid;

endpackage

/* hw/rtl/f64rhu_pack.sv */
// Normalise-and-pack stage: count leading zeros of the integer, build binary64.
module f64rhu_pack
    import f64rhu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_mid            i_mid,
    output logic            o_valid,
    output t_word           o_word
);
    logic [5:0]     n_lz;
    logic           r_valid;
    logic [5:0]     r_lz;
    t_mid           r_mid;
    logic [FracW:0] w_sh;
    logic [ExpW-1:0] w_exp;

    always_comb begin
        n_lz = 6'd0;
        for (int i = 0; i <= FracW; i++) begin
            if (i_mid.n[i]) begin
                n_lz = 6'(FracW - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lz  <= n_lz;
            r_mid <= i_mid;
        end
    end

    assign w_sh  = r_mid.n << r_lz;
    assign w_exp = ExpBias + ExpW'(FracW) - ExpW'(r_lz);

    assign o_valid = r_valid;
    assign o_word  = r_mid.pass ? r_mid.word : {r_mid.sign, w_exp, w_sh[FracW-1:0]};
endmodule

/* hw/rtl/float64_round_half_up_core.sv */
// Top level: pipelined binary64 round-to-integer, ties toward +infinity.
// Accepts one item per cycle while the output is not stalled; the pipeline stages are decode and
// offset add, integer shift, leading-zero count, then pack into the output register.
// A full stall freezes every stage together; no item is lost or repeated.
module float64_round_half_up_core
    import f64rhu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_bits[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // rounded_bits[63:0]
);
    logic en;
    logic r_v1, r_v2;
    logic r_pass1, r_sign1;
    logic [FracW+1:0] r_sum1;
    logic [5:0] r_f1;
    t_word r_word1;
    t_mid r_mid2;
    logic p_valid;
    t_word p_word;
    logic r_ov;
    t_word r_od;

    logic            w_sign;
    logic [ExpW-1:0] w_e;
    logic [FracW-1:0] w_frac;
    logic [FracW:0]  w_m;
    logic [5:0]      w_f;
    logic [FracW+1:0] w_add;
    logic            w_pass;
    t_word           w_word;

    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        w_sign = s_axis_tdata[63];
        w_e    = s_axis_tdata[62:52];
        w_frac = s_axis_tdata[51:0];
        w_m    = {1'b1, w_frac};
        w_f    = 6'(ExpInt - w_e);
        w_pass = 1'b0;
        w_word = s_axis_tdata;
        w_add  = '0;
        if (w_e == ExpMax || w_e >= ExpInt || (w_e == '0 && w_frac == '0)) begin
            w_pass = 1'b1;
        end else if (w_e < ExpHalf || (w_sign && w_e == ExpHalf && w_frac == '0)) begin
            w_pass = 1'b1;
            w_word = {w_sign, 63'd0};
        end else if (!w_sign) begin
            w_add = {1'b0, w_m} + ((FracW+2)'(1) << (w_f - 6'd1));
        end else begin
            w_add = {1'b0, w_m} + ((FracW+2)'(1) << (w_f - 6'd1)) - (FracW+2)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_ov <= p_valid;
        end
        if (en) begin
            r_pass1 <= w_pass;
            r_sign1 <= w_sign;
            r_sum1  <= w_add;
            r_f1    <= w_f;
            r_word1 <= w_word;
            r_mid2.pass <= r_pass1;
            r_mid2.sign <= r_sign1;
            r_mid2.n    <= (FracW+1)'(r_sum1 >> r_f1);
            r_mid2.word <= r_word1;
            r_od <= p_word;
        end
    end

    f64rhu_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_mid   (r_mid2),
        .o_valid (p_valid),
        .o_word  (p_word)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
endmodule

/* verif/float64_round_half_up_core_test.sv */
// Testbench for the binary64 round-half-up core: corners, a pause, random operands, stalls.
`timescale 1ns / 100ps

module float64_round_half_up_core_test
    import f64rhu_pkg::*;
;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // operand_bits[63:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // rounded_bits[63:0]

    t_word       rounded_q[$];
    int unsigned n_errors;
    int unsigned idle_cycles;
    bit          stall_random;

    float64_round_half_up_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Pack a nonzero integer magnitude with a sign.
    function automatic t_word pack_int(logic sgn, logic [63:0] mag);
        int p;
        p = 0;
        for (int k = 0; k < 64; k++) begin
            if (mag[k]) p = k;
        end
        return {sgn, 11'(int'(ExpBias) + p), 52'((mag << (52 - p)))};
    endfunction

    function automatic t_word round_half_up(t_word b);
        logic            sgn;
        logic [ExpW-1:0] ex;
        logic [FracW-1:0] fr;
        logic [63:0]     m;
        logic [63:0]     half;
        int              f;
        sgn = b[63];
        ex  = b[62:52];
        fr  = b[51:0];
        if (ex == ExpMax) return b;
        if (ex == '0 && fr == '0) return b;
        if (ex < ExpHalf) return {sgn, 63'd0};
        if (ex >= ExpInt) return b;
        m    = {11'd0, 1'b1, fr};
        f    = int'(ExpInt) - int'(ex);
        half = 64'd1 << (f - 1);
        if (!sgn) return pack_int(1'b0, (m + half) >> f);
        if (ex == ExpHalf && fr == '0) return {1'b1, 63'd0};
        return pack_int(1'b1, (m - half + (64'd1 << f) - 64'd1) >> f);
    endfunction

    // valid stays high after the handshake; gaps and drain drop it
    task automatic send_operand(t_word x);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        rounded_q.push_back(round_half_up(x));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_bursty(t_word x);
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        send_operand(x);
    endtask

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic test_corners();
        t_word v[$];
        v = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
              64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000,
              64'hBFE0_0000_0000_0000, 64'h3FDF_FFFF_FFFF_FFFF, 64'hBFDF_FFFF_FFFF_FFFF,
              64'h3FE0_0000_0000_0001, 64'hBFE0_0000_0000_0001, 64'h3FF8_0000_0000_0000,
              64'hBFF8_0000_0000_0000, 64'h4004_0000_0000_0000, 64'hC004_0000_0000_0000,
              64'h432F_FFFF_FFFF_FFFF, 64'hC32F_FFFF_FFFF_FFFF, 64'h4330_0000_0000_0001,
              64'hC330_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF,
              64'hBFEF_FFFF_FFFF_FFFF};
        foreach (v[k]) send_operand(v[k]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (rounded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random(int unsigned count);
        t_word x;
        for (int unsigned k = 0; k < count; k++) begin
            x = rand_word();
            // mostly exponents in the rounding range
            if ($urandom_range(0, 9) < 7) x[62:52] = 11'($urandom_range(1018, 1077));
            else if ($urandom_range(0, 3) == 0) x[62:52] = ExpMax;
            else if ($urandom_range(0, 3) == 0) x[62:52] = '0;
            send_bursty(x);
        end
    endtask

    task automatic test_pause();
        send_operand(64'h4002_0000_0000_0000);
        drain();
        send_operand(64'hC002_0000_0000_0000);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (rounded_q.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, m_axis_tdata);
                    n_errors++;
                end else begin
                    if (m_axis_tdata !== rounded_q[0]) begin
                        $display("%0t: rounded_bits expected %h actual %h",
                                 $time, rounded_q[0], m_axis_tdata);
                        n_errors++;
                    end
                    void'(rounded_q.pop_front());
                end
            end
            m_axis_tready <= stall_random ? ($urandom_range(0, 3) != 0) : 1'b1;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        n_errors      = 0;
        idle_cycles   = 0;
        stall_random  = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_pause();
        stall_random = 1'b1;
        test_random(700);
        drain();
        stall_random = 1'b0;
        test_random(400);
        stall_random = 1'b1;
        test_random(320);
        drain();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
